// ===== sv/lpfp_pkg.sv =====
// shared types, constants and the crc-8 step for the length prefixed frame parser
// no dependencies
package lpfp_pkg;

  localparam int unsigned MaxPreambleBytes = 4;
  localparam int unsigned PreambleBound    = (MaxPreambleBytes < 4) ? MaxPreambleBytes : 4;

  localparam logic [31:0] PreamblePatternRst = 32'd0;
  localparam logic [2:0]  PreambleLengthRst  = 3'd4;
  localparam logic [15:0] MaxPayloadRst      = 16'd256;
  localparam logic [7:0]  CrcPolynomialRst   = 8'd7;

  localparam int unsigned CfgAddrWidth = 4;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_LEN  = 4'b0010,
    PH_BODY = 4'b0100,
    PH_CHK  = 4'b1000
  } phase_e;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_CRC_GOOD   = 2'd1,
    ST_CRC_BAD    = 2'd2,
    ST_TOO_LONG   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_PREAMBLE_PATTERN = 2'd0,
    REG_PREAMBLE_LENGTH  = 2'd1,
    REG_MAX_PAYLOAD      = 2'd2,
    REG_CRC_POLYNOMIAL   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  status;
    logic        body_valid;
    logic [7:0]  body_byte;
    logic [15:0] body_index;
    logic [15:0] frame_length;
  } result_t;

  // one byte through the msb-first crc-8 register
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b,
                                             input logic [7:0] poly);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ poly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/length_prefixed_frame_parser_crc8.sv =====
// length prefixed frame parser: preamble hunt, 16-bit length, body, crc-8 check byte
// depends on lpfp_pkg
//
// Usage: received bytes enter on the input channel (in_valid_i, in_stall_o, rx_byte_i),
// one word per byte. Every accepted byte yields exactly one result word on the output
// channel (out_valid_o, out_stall_i): status, body_valid, body_byte, body_index and
// frame_length. Status is 0 while a frame is incomplete, 1 or 2 on the check byte
// (crc good or bad) and 3 when the decoded length exceeds max_payload.
// Each result is registered in the output or skid register. While in_stall_o is low,
// throughput is one byte per cycle; the parser state and the crc are updated in the
// same cycle the byte is taken, with the crc-8 register stepped by combinational logic.
// When the receiver stalls, the output register holds its word and one more result
// goes to a skid register; in_stall_o rises only while the skid register is full.
// Reset returns the parser to the preamble hunt, clears its counters and crc and loads
// the register defaults (pattern 0, length 4, max payload 256, polynomial 0x07).
// Registers are written over the apb port at byte addresses 0, 4, 8 and 12.
module length_prefixed_frame_parser_crc8 (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [1:0]                       status_o,
  output logic                             body_valid_o,
  output logic [7:0]                       body_byte_o,
  output logic [15:0]                      body_index_o,
  output logic [15:0]                      frame_length_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lpfp_pkg::CfgAddrWidth-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [31:0] preamble_pattern_q;
  logic [2:0]  preamble_length_q;
  logic [15:0] max_payload_q;
  logic [7:0]  crc_polynomial_q;

  lpfp_pkg::phase_e phase_q, phase_d;
  logic [15:0] byte_cnt_q, byte_cnt_d;
  logic [7:0]  len_low_q, len_low_d;
  logic [15:0] exp_len_q, exp_len_d;
  logic [7:0]  crc_q, crc_d;

  lpfp_pkg::result_t res;
  lpfp_pkg::result_t out_q, skid_q;
  logic out_valid_q, skid_valid_q;

  logic in_accept, out_take, cfg_write;
  lpfp_pkg::reg_idx_e cfg_idx;
  logic [2:0]  eff_len;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;
  logic [7:0]  want_byte;

  assign in_accept = in_valid_i && !skid_valid_q;
  assign out_take  = out_valid_q && !out_stall_i;
  assign in_stall_o = skid_valid_q;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_idx   = lpfp_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    unique case (cfg_idx)
      lpfp_pkg::REG_PREAMBLE_PATTERN: prdata = preamble_pattern_q;
      lpfp_pkg::REG_PREAMBLE_LENGTH:  prdata = {29'd0, preamble_length_q};
      lpfp_pkg::REG_MAX_PAYLOAD:      prdata = {16'd0, max_payload_q};
      lpfp_pkg::REG_CRC_POLYNOMIAL:   prdata = {24'd0, crc_polynomial_q};
      default:                        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_pattern_q <= lpfp_pkg::PreamblePatternRst;
      preamble_length_q  <= lpfp_pkg::PreambleLengthRst;
      max_payload_q      <= lpfp_pkg::MaxPayloadRst;
      crc_polynomial_q   <= lpfp_pkg::CrcPolynomialRst;
    end else if (cfg_write) begin
      unique case (cfg_idx)
        lpfp_pkg::REG_PREAMBLE_PATTERN: preamble_pattern_q <= pwdata;
        lpfp_pkg::REG_PREAMBLE_LENGTH:  preamble_length_q  <= pwdata[2:0];
        lpfp_pkg::REG_MAX_PAYLOAD:      max_payload_q      <= pwdata[15:0];
        lpfp_pkg::REG_CRC_POLYNOMIAL:   crc_polynomial_q   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // zero counts as one, anything above the bound saturates
  always_comb begin
    if (preamble_length_q == 3'd0) begin
      eff_len = 3'd1;
    end else if (preamble_length_q > 3'(lpfp_pkg::PreambleBound)) begin
      eff_len = 3'(lpfp_pkg::PreambleBound);
    end else begin
      eff_len = preamble_length_q;
    end
  end

  assign cnt_inc   = byte_cnt_q + 16'd1;
  assign len_full  = {rx_byte_i, len_low_q};
  assign want_byte = preamble_pattern_q[{byte_cnt_q[1:0], 3'b000} +: 8];

  always_comb begin
    phase_d   = phase_q;
    byte_cnt_d = byte_cnt_q;
    len_low_d = len_low_q;
    exp_len_d = exp_len_q;
    crc_d     = crc_q;
    res       = '0;
    unique case (phase_q)
      lpfp_pkg::PH_HUNT: begin
        // a mismatching byte is not retried as a first preamble byte
        if (rx_byte_i == want_byte) begin
          if (cnt_inc >= {13'd0, eff_len}) begin
            byte_cnt_d = 16'd0;
            phase_d    = lpfp_pkg::PH_LEN;
          end else begin
            byte_cnt_d = cnt_inc;
          end
        end else begin
          byte_cnt_d = 16'd0;
        end
      end
      lpfp_pkg::PH_LEN: begin
        if (byte_cnt_q == 16'd0) begin
          len_low_d  = rx_byte_i;
          byte_cnt_d = 16'd1;
        end else begin
          exp_len_d        = len_full;
          res.frame_length = len_full;
          byte_cnt_d       = 16'd0;
          if (len_full > max_payload_q) begin
            res.status = lpfp_pkg::ST_TOO_LONG;
            phase_d    = lpfp_pkg::PH_HUNT;
          end else begin
            crc_d = lpfp_pkg::crc8_update(
                      lpfp_pkg::crc8_update(8'd0, len_low_q, crc_polynomial_q),
                      rx_byte_i, crc_polynomial_q);
            phase_d = (len_full == 16'd0) ? lpfp_pkg::PH_CHK : lpfp_pkg::PH_BODY;
          end
        end
      end
      lpfp_pkg::PH_BODY: begin
        res.frame_length = exp_len_q;
        res.body_valid   = 1'b1;
        res.body_byte    = rx_byte_i;
        res.body_index   = byte_cnt_q;
        crc_d = lpfp_pkg::crc8_update(crc_q, rx_byte_i, crc_polynomial_q);
        if (cnt_inc >= exp_len_q) begin
          byte_cnt_d = 16'd0;
          phase_d    = lpfp_pkg::PH_CHK;
        end else begin
          byte_cnt_d = cnt_inc;
        end
      end
      lpfp_pkg::PH_CHK: begin
        res.frame_length = exp_len_q;
        res.status = (crc_q == rx_byte_i) ? lpfp_pkg::ST_CRC_GOOD : lpfp_pkg::ST_CRC_BAD;
        byte_cnt_d = 16'd0;
        phase_d    = lpfp_pkg::PH_HUNT;
      end
      default: begin
        phase_d    = lpfp_pkg::PH_HUNT;
        byte_cnt_d = 16'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= lpfp_pkg::PH_HUNT;
      byte_cnt_q <= 16'd0;
      len_low_q  <= 8'd0;
      exp_len_q  <= 16'd0;
      crc_q      <= 8'd0;
    end else if (in_accept) begin
      phase_q    <= phase_d;
      byte_cnt_q <= byte_cnt_d;
      len_low_q  <= len_low_d;
      exp_len_q  <= exp_len_d;
      crc_q      <= crc_d;
    end
  end

  // output register with one skid word behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (skid_valid_q) begin
        if (out_take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (in_accept) begin
        if (out_valid_q && out_stall_i) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_accept) begin
      if (out_valid_q && out_stall_i) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign body_valid_o   = out_q.body_valid;
  assign body_byte_o    = out_q.body_byte;
  assign body_index_o   = out_q.body_index;
  assign frame_length_o = out_q.frame_length;

endmodule
